@@ rtl/core/mcr_pkg.sv @@
// Types, constants and ramp colour tables for the colour ramp pipeline.
`timescale 1ns / 1ps
`default_nettype none
package mcr_pkg;

  localparam int COLOR_BITS = 8;
  localparam int COLOR_MAX  = (1 << COLOR_BITS) - 1;
  localparam int IN_W       = 80;
  localparam int OUT_W      = ((3 * COLOR_BITS + 7) / 8) * 8;
  // blended channel in 1/65536000 units, scaled value, quotient by 1000
  localparam int C_W        = 27;
  localparam int X_W        = C_W + COLOR_BITS;
  localparam int Y_W        = X_W - 16;
  localparam logic [22:0] RCP_1000 = 23'((64'd1 << 32) / 1000);

  typedef logic [2:0][9:0] rgb_t;

  typedef enum logic [2:0] {
    MODE_TOPO   = 3'd0,
    MODE_VEG    = 3'd1,
    MODE_TEMP   = 3'd2,
    MODE_ARID   = 3'd3,
    MODE_PRECIP = 3'd4
  } mode_t;

  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_SEA  = 1'b1;

  typedef enum logic [3:0] {
    DEN_70, DEN_160, DEN_240, DEN_400, DEN_500,
    DEN_630, DEN_2048, DEN_2500, DEN_4096, DEN_6144
  } den_t;

  function automatic logic [12:0] den_val(input den_t d);
    case (d)
      DEN_70:   den_val = 13'd70;
      DEN_160:  den_val = 13'd160;
      DEN_240:  den_val = 13'd240;
      DEN_400:  den_val = 13'd400;
      DEN_500:  den_val = 13'd500;
      DEN_630:  den_val = 13'd630;
      DEN_2048: den_val = 13'd2048;
      DEN_2500: den_val = 13'd2500;
      DEN_4096: den_val = 13'd4096;
      DEN_6144: den_val = 13'd6144;
      default:  den_val = 13'd500;
    endcase
  endfunction

  // floor(2^36 / den)
  function automatic logic [29:0] den_rcp(input den_t d);
    case (d)
      DEN_70:   den_rcp = 30'((64'd1 << 36) / 70);
      DEN_160:  den_rcp = 30'((64'd1 << 36) / 160);
      DEN_240:  den_rcp = 30'((64'd1 << 36) / 240);
      DEN_400:  den_rcp = 30'((64'd1 << 36) / 400);
      DEN_500:  den_rcp = 30'((64'd1 << 36) / 500);
      DEN_630:  den_rcp = 30'((64'd1 << 36) / 630);
      DEN_2048: den_rcp = 30'((64'd1 << 36) / 2048);
      DEN_2500: den_rcp = 30'((64'd1 << 36) / 2500);
      DEN_4096: den_rcp = 30'((64'd1 << 36) / 4096);
      DEN_6144: den_rcp = 30'((64'd1 << 36) / 6144);
      default:  den_rcp = 30'((64'd1 << 36) / 500);
    endcase
  endfunction

  function automatic rgb_t mk_rgb(input int r, input int g, input int b);
    rgb_t c;
    c[0] = 10'(r);
    c[1] = 10'(g);
    c[2] = 10'(b);
    return c;
  endfunction

  localparam rgb_t BLACK = mk_rgb(0, 0, 0);

  localparam rgb_t TOPO_WATER [3] = '{
    mk_rgb(0, 400, 600), mk_rgb(0, 120, 500), mk_rgb(0, 0, 250)};
  localparam rgb_t TOPO_LAND [6] = '{
    mk_rgb(0, 400, 0), mk_rgb(0, 700, 0), mk_rgb(1000, 1000, 0),
    mk_rgb(1000, 500, 0), mk_rgb(700, 0, 0), mk_rgb(100, 100, 100)};

  localparam rgb_t VEG_WHITE   = mk_rgb(1000, 1000, 1000);
  localparam rgb_t VEG_DEEP    = mk_rgb(50, 50, 200);
  localparam rgb_t VEG_SHALLOW = mk_rgb(40, 220, 420);
  localparam rgb_t VEG_LOW     = mk_rgb(950, 810, 530);
  localparam rgb_t VEG_HIGH    = mk_rgb(100, 100, 100);
  localparam rgb_t VEG_PLANT   = mk_rgb(176, 320, 50);

  localparam rgb_t TEMP_COLS [8] = '{
    mk_rgb(1000, 1000, 1000), mk_rgb(700, 0, 500), mk_rgb(0, 0, 500),
    mk_rgb(0, 0, 1000), mk_rgb(0, 1000, 1000), mk_rgb(1000, 1000, 0),
    mk_rgb(1000, 100, 0), mk_rgb(450, 0, 0)};
  localparam logic signed [11:0] TEMP_LIM [8] = '{
    -12'sd800, -12'sd560, -12'sd320, -12'sd160,
    12'sd0, 12'sd160, 12'sd320, 12'sd480};

  localparam rgb_t ARID_COLS [4] = '{
    mk_rgb(1000, 0, 0), mk_rgb(1000, 1000, 0), mk_rgb(0, 1000, 0), mk_rgb(0, 500, 0)};

  localparam rgb_t PREC_DRY = mk_rgb(1000, 1000, 500);
  localparam rgb_t PREC_MID = mk_rgb(0, 1000, 0);
  localparam rgb_t PREC_WET = mk_rgb(0, 0, 1000);

endpackage
`default_nettype wire

@@ rtl/core/map_color_ramp.sv @@
// Map tile colouring: eight-stage piecewise-linear colour ramp pipeline.
//
// Input transactions on s_axis carry one tile's measurements; each yields
// exactly one RGB transaction on m_axis, in order.
// The cfg channel writes display_mode (index 0) and sea_level_m (index 1);
// cfg_ready is always high. Write it only while the pipeline is empty.
// One tile per clock is sustained while m_axis_tready is high. Stages are
// decode, reciprocal multiply, factor correction, colour blend, vegetation
// blend, scaling, and a two-stage divide by 1000.
// All stages advance together; when m_axis_tready is low with a result
// waiting, the whole pipeline holds and s_axis_tready drops, so nothing is
// lost or repeated. Reset (rst, synchronous) empties the pipeline and sets
// topography mode with sea level zero.
// Unused modes give black.
`timescale 1ns / 1ps
`default_nettype none
module map_color_ramp
  import mcr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // elevation_m, water_depth_m, temp_rel_freeze, aridity_q12, precip_units
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  // water flag
  input  wire logic             s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // red, green, blue
  output logic [OUT_W-1:0]      m_axis_tdata,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic             cfg_index,
  input  wire logic [15:0]      cfg_data
);

  logic [2:0]         mode;
  logic signed [15:0] sea;
  logic               ce;
  logic [8:1]         vld;

  assign cfg_ready     = 1'b1;
  assign ce            = !vld[8] || m_axis_tready;
  assign s_axis_tready = ce;
  assign m_axis_tvalid = vld[8];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_TOPO;
      sea  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MODE: mode <= cfg_data[2:0];
        CFG_SEA:  sea  <= cfg_data;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[7:1], s_axis_tvalid};
    end
  end

  // ---------------- stage 1: decode
  logic               in_water;
  logic signed [15:0] in_elev;
  logic [13:0]        in_depth;
  logic signed [11:0] in_temp;
  logic [15:0]        in_arid;
  logic [15:0]        in_prec;
  logic signed [17:0] elev;
  logic signed [17:0] temp18;
  logic signed [17:0] arid18;
  logic signed [17:0] prec18;
  rgb_t               d_a, d_b;
  logic signed [17:0] d_num;
  den_t               d_den;
  logic               d_solid, d_veg;

  assign in_water = s_axis_tuser;
  assign in_elev  = s_axis_tdata[15:0];
  assign in_depth = s_axis_tdata[29:16];
  assign in_temp  = s_axis_tdata[41:30];
  assign in_arid  = s_axis_tdata[57:42];
  assign in_prec  = s_axis_tdata[73:58];
  assign elev     = {{2{in_elev[15]}}, in_elev} - {{2{sea[15]}}, sea};
  assign temp18   = {{6{in_temp[11]}}, in_temp};
  assign arid18   = {2'b00, in_arid};
  assign prec18   = {2'b00, in_prec};

  always_comb begin
    d_a     = BLACK;
    d_b     = BLACK;
    d_num   = '0;
    d_den   = DEN_500;
    d_solid = 1'b1;
    d_veg   = 1'b0;
    case (mode)
      MODE_TOPO: begin
        if (in_water) begin
          if (elev < -18'sd1000) begin
            d_a = TOPO_WATER[2];
          end else if (elev < -18'sd500) begin
            d_a = TOPO_WATER[1]; d_b = TOPO_WATER[2];
            d_num = -18'sd500 - elev; d_solid = 1'b0;
          end else begin
            d_a = TOPO_WATER[0]; d_b = TOPO_WATER[1];
            d_num = -elev; d_solid = 1'b0;
          end
        end else begin
          d_a = TOPO_LAND[5];
          // first segment whose top is at or above the elevation
          for (int i = 4; i >= 0; i--) begin
            if (elev <= 18'(i * 500)) begin
              d_a = TOPO_LAND[i]; d_b = TOPO_LAND[i+1];
              d_num = elev - 18'(i * 500 - 500); d_solid = 1'b0;
            end
          end
        end
      end
      MODE_VEG: begin
        if (in_water) begin
          d_a = VEG_SHALLOW; d_b = VEG_DEEP;
          d_num = {4'b0, in_depth}; d_den = DEN_400; d_solid = 1'b0;
        end else if (in_temp <= 12'sd0) begin
          d_a = VEG_WHITE;
        end else begin
          d_a = VEG_LOW; d_b = VEG_HIGH;
          d_num = elev; d_den = DEN_2500; d_solid = 1'b0; d_veg = 1'b1;
        end
      end
      MODE_TEMP: begin
        if (in_temp <= TEMP_LIM[0]) begin
          d_a = TEMP_COLS[0];
        end else if (in_temp >= TEMP_LIM[7]) begin
          d_a = TEMP_COLS[7];
        end else begin
          for (int i = 0; i < 7; i++) begin
            if (in_temp >= TEMP_LIM[i] && in_temp < TEMP_LIM[i+1]) begin
              d_a = TEMP_COLS[i]; d_b = TEMP_COLS[i+1];
              d_num = temp18 - {{6{TEMP_LIM[i][11]}}, TEMP_LIM[i]};
              d_den = (i < 2) ? DEN_240 : DEN_160;
              d_solid = 1'b0;
            end
          end
        end
      end
      MODE_ARID: begin
        if (in_water) begin
          d_a = VEG_WHITE;
        end else if (in_arid > 16'd4096) begin
          d_a = ARID_COLS[1]; d_b = ARID_COLS[0];
          d_num = arid18 - 18'sd4096; d_den = DEN_4096; d_solid = 1'b0;
        end else if (in_arid > 16'd2048) begin
          d_a = ARID_COLS[2]; d_b = ARID_COLS[1];
          d_num = arid18 - 18'sd2048; d_den = DEN_2048; d_solid = 1'b0;
        end else if (in_arid > 16'd0) begin
          d_a = ARID_COLS[3]; d_b = ARID_COLS[2];
          d_num = arid18; d_den = DEN_2048; d_solid = 1'b0;
        end else begin
          d_a = ARID_COLS[3];
        end
      end
      MODE_PRECIP: begin
        if (in_water) begin
          d_a = VEG_WHITE;
        end else if (in_prec < 16'd70) begin
          d_a = PREC_DRY; d_b = PREC_MID;
          d_num = prec18; d_den = DEN_70; d_solid = 1'b0;
        end else begin
          d_a = PREC_MID; d_b = PREC_WET;
          d_num = prec18 - 18'sd70; d_den = DEN_630; d_solid = 1'b0;
        end
      end
      default: ;
    endcase
  end

  logic d_zero, d_full;
  assign d_zero = d_solid || (d_num <= 18'sd0);
  assign d_full = !d_zero && (d_num >= $signed({5'b0, den_val(d_den)}));

  rgb_t        s1_a, s1_b;
  logic [12:0] s1_num, s1_vnum;
  den_t        s1_den;
  logic        s1_zero, s1_full, s1_vzero, s1_vfull, s1_veg;

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_a     <= d_a;
      s1_b     <= d_b;
      s1_num   <= d_num[12:0];
      s1_den   <= d_den;
      s1_zero  <= d_zero;
      s1_full  <= d_full;
      s1_veg   <= d_veg;
      s1_vnum  <= in_arid[12:0];
      s1_vzero <= (in_arid == 16'd0);
      s1_vfull <= (in_arid >= 16'd6144);
    end
  end

  // ---------------- stage 2: reciprocal estimate, floor or one below
  logic [42:0] p2_t, p2_v;
  assign p2_t = 43'(s1_num) * 43'(den_rcp(s1_den));
  assign p2_v = 43'(s1_vnum) * 43'(den_rcp(DEN_6144));

  rgb_t        s2_a, s2_b;
  logic [12:0] s2_num, s2_vnum;
  logic [15:0] s2_q, s2_vq;
  den_t        s2_den;
  logic        s2_zero, s2_full, s2_vzero, s2_vfull, s2_veg;

  always_ff @(posedge clk) begin
    if (ce) begin
      s2_a     <= s1_a;
      s2_b     <= s1_b;
      s2_num   <= s1_num;
      s2_vnum  <= s1_vnum;
      s2_q     <= p2_t[35:20];
      s2_vq    <= p2_v[35:20];
      s2_den   <= s1_den;
      s2_zero  <= s1_zero;
      s2_full  <= s1_full;
      s2_vzero <= s1_vzero;
      s2_vfull <= s1_vfull;
      s2_veg   <= s1_veg;
    end
  end

  // ---------------- stage 3: correct the estimate, saturate
  logic [28:0] r3_t, r3_v;
  logic [16:0] f3_t, f3_v;
  assign r3_t = {s2_num, 16'b0} - 29'(s2_q) * 29'(den_val(s2_den));
  assign r3_v = {s2_vnum, 16'b0} - 29'(s2_vq) * 29'(den_val(DEN_6144));

  always_comb begin
    if (s2_zero)      f3_t = '0;
    else if (s2_full) f3_t = 17'd65536;
    else f3_t = 17'(s2_q) + 17'(r3_t >= 29'(den_val(s2_den)));
    if (s2_vzero)      f3_v = '0;
    else if (s2_vfull) f3_v = 17'd65536;
    else f3_v = 17'(s2_vq) + 17'(r3_v >= 29'(den_val(DEN_6144)));
  end

  rgb_t        s3_a, s3_b;
  logic [16:0] s3_t, s3_v;
  logic        s3_veg;

  always_ff @(posedge clk) begin
    if (ce) begin
      s3_a   <= s2_a;
      s3_b   <= s2_b;
      s3_t   <= f3_t;
      s3_v   <= f3_v;
      s3_veg <= s2_veg;
    end
  end

  // ---------------- stage 4: colour blend
  logic [2:0][C_W-1:0] w4;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      w4[k] = C_W'(s3_a[k]) * C_W'(17'd65536 - s3_t) + C_W'(s3_b[k]) * C_W'(s3_t);
    end
  end

  logic [2:0][C_W-1:0] s4_w;
  logic [16:0]         s4_v;
  logic                s4_veg;

  always_ff @(posedge clk) begin
    if (ce) begin
      s4_w   <= w4;
      s4_v   <= s3_v;
      s4_veg <= s3_veg;
    end
  end

  // ---------------- stage 5: plant colour against ground by aridity
  logic [2:0][C_W-1:0] c5;
  logic [2:0][43:0]    p5;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p5[k] = 44'(s4_w[k]) * 44'(s4_v);
      if (s4_veg)
        c5[k] = C_W'(VEG_PLANT[k]) * C_W'(17'd65536 - s4_v) + p5[k][C_W+15:16];
      else
        c5[k] = s4_w[k];
    end
  end

  logic [2:0][C_W-1:0] s5_c;
  always_ff @(posedge clk) begin
    if (ce) s5_c <= c5;
  end

  // ---------------- stage 6: scale to channel range, divide by 65536
  logic [2:0][X_W-1:0] x6;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      x6[k] = X_W'(s5_c[k]) * X_W'(COLOR_MAX) + X_W'(32768000);
    end
  end

  logic [2:0][Y_W-1:0] s6_y;
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 3; k++) s6_y[k] <= x6[k][X_W-1:16];
    end
  end

  // ---------------- stage 7: divide by 1000, estimate
  logic [2:0][Y_W+22:0] p7;
  always_comb begin
    for (int k = 0; k < 3; k++) p7[k] = (Y_W+23)'(s6_y[k]) * (Y_W+23)'(RCP_1000);
  end

  logic [2:0][Y_W-1:0]        s7_y;
  logic [2:0][COLOR_BITS-1:0] s7_q;
  always_ff @(posedge clk) begin
    if (ce) begin
      s7_y <= s6_y;
      for (int k = 0; k < 3; k++) s7_q[k] <= p7[k][32+COLOR_BITS-1:32];
    end
  end

  // ---------------- stage 8: correct quotient, output register
  logic [2:0][Y_W-1:0]        r8;
  logic [2:0][COLOR_BITS-1:0] ch8;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      r8[k]  = s7_y[k] - Y_W'(s7_q[k]) * Y_W'(1000);
      ch8[k] = s7_q[k] + COLOR_BITS'(r8[k] >= Y_W'(1000));
    end
  end

  logic [2:0][COLOR_BITS-1:0] s8_ch;
  always_ff @(posedge clk) begin
    if (ce) s8_ch <= ch8;
  end

  assign m_axis_tdata = OUT_W'(s8_ch);

  ast_t_range: assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> s3_t <= 17'd65536)
    else $error("blend factor out of range");

  ast_v_range: assert property (@(posedge clk) disable iff (rst)
    (vld[3] && s3_veg) |-> s3_v <= 17'd65536)
    else $error("aridity factor out of range");

  ast_advance: assert property (@(posedge clk) disable iff (rst)
    (vld[7] && ce) |=> m_axis_tvalid)
    else $error("result lost between last stages");

  ast_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while pipeline stalled");

endmodule
`default_nettype wire
